### hdl/btq_pkg.sv
// ----------------------------------------------------------------------------
// btq_pkg
// Types and constants shared by the bounded top-k sorted queue and its cells.
// ----------------------------------------------------------------------------
package btq_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int NUM_GRAPHS = 64;
  localparam int HALF_SLOTS = MAX_SLOTS / 2;

  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int SUPPORT_W = $clog2(NUM_GRAPHS + 1);
  localparam int KEY_W     = 32;
  localparam int SCORE_W   = 32;
  localparam int STAMP_W   = 32;
  localparam int GID_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int TOPK_W    = 3;
  localparam int SUM_W     = SCORE_W + SLOT_W;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [TOPK_W-1:0] TOPK_RESET = TOPK_W'(3);

  typedef enum logic [STATUS_W-1:0] {
    ST_REJECTED = 3'd0,
    ST_ADDED    = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_EVICTED  = 3'd4,
    ST_READ     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_ADD_GRAPH = 2'd1,
    ACT_INSERT    = 2'd2
  } action_t;

  typedef struct packed {
    logic                      operation;
    logic [KEY_W-1:0]          pattern_key;
    logic [GID_W-1:0]          graph_index;
    logic signed [SCORE_W-1:0] sample_score;
    logic [SLOT_W-1:0]         read_index;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [SLOT_W-1:0]         slot;
    logic [COUNT_W-1:0]        entry_count;
    logic [KEY_W-1:0]          entry_key;
    logic [SUPPORT_W-1:0]      entry_support;
    logic signed [SCORE_W-1:0] entry_score;
    logic [STAMP_W-1:0]        entry_time;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [NUM_GRAPHS-1:0]     graphs;
    logic [STAMP_W-1:0]        stamp;
    logic [SUPPORT_W-1:0]      support;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [GID_W-1:0]          graph_index;
    logic signed [SCORE_W-1:0] score;
    logic [STAMP_W-1:0]        stamp;
  } probe_t;

  typedef struct packed {
    logic match;
    logic has_graph;
    logic ranks_below;
  } flags_t;

  typedef struct packed {
    action_t           action;
    logic [SLOT_W-1:0] target;
    logic              evict;
  } cmd_t;

endpackage

### hdl/bounded_topk_sorted_queue_unit.sv
// ----------------------------------------------------------------------------
// bounded_topk_sorted_queue_unit
// Bounded candidate queue in ascending order, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Every beat, offer or read, has an evaluate step, in which each cell compares
// its entry with the held item and the lower-half score sum is registered, and
// a decide step, in which the action is chosen, the cells shift or load, and the
// result goes to the output register. The next beat is taken at that commit
// edge, not before, and the decide step waits while the output is stalled.
// Slot contents have no reset; only slots below the entry count are read.
module bounded_topk_sorted_queue_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  btq_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output btq_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [btq_pkg::TOPK_W-1:0] cfg_data
);

  localparam int CAP_W = (btq_pkg::TOPK_W + 1 > btq_pkg::COUNT_W) ?
                         btq_pkg::TOPK_W + 1 : btq_pkg::COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DECIDE} state_t;

  state_t                         state;
  btq_pkg::in_item_t              item;
  logic [btq_pkg::COUNT_W-1:0]    fill_count;
  logic [btq_pkg::STAMP_W-1:0]    iteration;
  logic [btq_pkg::TOPK_W-1:0]     top_k;
  logic signed [btq_pkg::SUM_W-1:0] half_sum;

  btq_pkg::entry_t entries [btq_pkg::MAX_SLOTS];
  btq_pkg::flags_t flags   [btq_pkg::MAX_SLOTS];
  btq_pkg::probe_t probe;
  btq_pkg::cmd_t   cmd;
  btq_pkg::cmd_t   cmd_apply;
  btq_pkg::out_item_t res;

  logic                           accept;
  logic                           out_free;
  logic                           commit;
  logic [btq_pkg::STAMP_W-1:0]    iter_inc;
  logic [btq_pkg::COUNT_W-1:0]    half;
  logic [btq_pkg::COUNT_W-1:0]    fill_next;
  logic [btq_pkg::COUNT_W-1:0]    fill_post;
  logic [btq_pkg::TOPK_W-1:0]     k_eff;
  logic [CAP_W-1:0]               cap_raw;
  logic [CAP_W-1:0]               cap;
  logic                           full;
  logic                           gid_bad;
  logic signed [btq_pkg::SUM_W-1:0] sum_comb;
  logic signed [btq_pkg::SUM_W-1:0] score_ext;
  logic signed [btq_pkg::SUM_W-1:0] prod;
  logic [btq_pkg::MAX_SLOTS-1:0]  match_mask;
  logic [btq_pkg::MAX_SLOTS-1:0]  lt_vec;
  logic [btq_pkg::MAX_SLOTS-1:0]  lt_sel;
  logic                           any_match;
  logic [btq_pkg::SLOT_W-1:0]     match_idx;
  logic [btq_pkg::SLOT_W-1:0]     pos;
  btq_pkg::entry_t                sel_entry;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) || ((state == S_DECIDE) && out_free));
  assign accept    = in_valid && !in_stall;
  assign commit    = (state == S_DECIDE) && out_free;
  assign iter_inc  = iteration + btq_pkg::STAMP_W'(1);

  assign probe.key         = item.pattern_key;
  assign probe.graph_index = item.graph_index;
  assign probe.score       = item.sample_score;
  assign probe.stamp       = iter_inc;

  assign cmd_apply = commit ? cmd : '0;

  for (genvar i = 0; i < btq_pkg::MAX_SLOTS; i++) begin : g_cell
    btq_pkg::entry_t below_e;
    btq_pkg::entry_t above_e;
    if (i == 0) begin : g_lo
      assign below_e = '0;
    end else begin : g_mid_lo
      assign below_e = entries[i-1];
    end
    if (i == btq_pkg::MAX_SLOTS - 1) begin : g_hi
      assign above_e = '0;
    end else begin : g_mid_hi
      assign above_e = entries[i+1];
    end
    btq_cell u_cell (
      .clk        (clk),
      .cell_index (btq_pkg::SLOT_W'(i)),
      .probe      (probe),
      .cmd        (cmd_apply),
      .below      (below_e),
      .above      (above_e),
      .entry      (entries[i]),
      .flags      (flags[i])
    );
    assign lt_vec[i]     = flags[i].ranks_below;
    assign match_mask[i] = flags[i].match && (btq_pkg::COUNT_W'(i) < fill_count);
  end

  // capacity and fullness
  always_comb begin
    k_eff   = (top_k == '0) ? btq_pkg::TOPK_W'(1) : top_k;
    cap_raw = CAP_W'({k_eff, 1'b0});
    cap     = (cap_raw > CAP_W'(btq_pkg::MAX_SLOTS)) ? CAP_W'(btq_pkg::MAX_SLOTS) : cap_raw;
    full    = CAP_W'(fill_count) >= cap;
    half    = fill_count >> 1;
    gid_bad = {1'b0, item.graph_index} >= (btq_pkg::GID_W + 1)'(btq_pkg::NUM_GRAPHS);
  end

  always_comb begin
    sum_comb = '0;
    for (int i = 0; i < btq_pkg::HALF_SLOTS; i++) begin
      if (btq_pkg::COUNT_W'(i) < half) begin
        sum_comb = sum_comb + btq_pkg::SUM_W'(entries[i].score);
      end
    end
  end

  // score times half by shift and add
  always_comb begin
    score_ext = btq_pkg::SUM_W'(item.sample_score);
    prod      = '0;
    for (int b = 0; b < btq_pkg::COUNT_W; b++) begin
      if (half[b]) begin
        prod = prod + (score_ext <<< b);
      end
    end
  end

  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int i = btq_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (match_mask[i]) begin
        any_match = 1'b1;
        match_idx = btq_pkg::SLOT_W'(i);
      end
    end
  end

  // slot j after eviction holds what slot j+1 holds now
  always_comb begin
    fill_post = full ? (fill_count - btq_pkg::COUNT_W'(1)) : fill_count;
    lt_sel    = full ? (lt_vec >> 1) : lt_vec;
    pos       = '0;
    for (int j = 0; j < btq_pkg::MAX_SLOTS; j++) begin
      if ((btq_pkg::COUNT_W'(j) < fill_post) && !lt_sel[j]) begin
        pos = btq_pkg::SLOT_W'(j + 1);
      end
    end
  end

  assign sel_entry = entries[(item.operation == btq_pkg::OP_READ) ? item.read_index : match_idx];

  always_comb begin
    res       = '0;
    cmd       = '0;
    fill_next = fill_count;
    if (item.operation == btq_pkg::OP_READ) begin
      res.status = btq_pkg::ST_READ;
      res.slot   = item.read_index;
      if (btq_pkg::COUNT_W'(item.read_index) < fill_count) begin
        res.entry_key     = sel_entry.key;
        res.entry_support = sel_entry.support;
        res.entry_score   = sel_entry.score;
        res.entry_time    = sel_entry.stamp;
      end
    end else if (gid_bad || (full && (prod < half_sum))) begin
      res.status = btq_pkg::ST_REJECTED;
    end else if (any_match) begin
      res.slot      = match_idx;
      res.entry_key = sel_entry.key;
      if (flags[match_idx].has_graph) begin
        res.status        = btq_pkg::ST_PRESENT;
        res.entry_support = sel_entry.support;
        res.entry_score   = sel_entry.score;
        res.entry_time    = sel_entry.stamp;
      end else begin
        res.status        = btq_pkg::ST_ADDED;
        res.entry_support = sel_entry.support + btq_pkg::SUPPORT_W'(1);
        res.entry_score   = sel_entry.score;
        res.entry_time    = iter_inc;
        cmd.action        = btq_pkg::ACT_ADD_GRAPH;
        cmd.target        = match_idx;
      end
    end else begin
      res.status        = full ? btq_pkg::ST_EVICTED : btq_pkg::ST_INSERTED;
      res.slot          = pos;
      res.entry_key     = item.pattern_key;
      res.entry_support = btq_pkg::SUPPORT_W'(1);
      res.entry_score   = item.sample_score;
      res.entry_time    = iter_inc;
      cmd.action        = btq_pkg::ACT_INSERT;
      cmd.target        = pos;
      cmd.evict         = full;
      fill_next         = fill_post + btq_pkg::COUNT_W'(1);
    end
    res.entry_count = fill_next;
  end

  always_ff @(posedge clk) begin
    half_sum <= sum_comb;
    if (accept) begin
      item <= in_data;
    end
    if (commit) begin
      out_data <= res;
    end
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      fill_count <= '0;
      iteration  <= '0;
      top_k      <= btq_pkg::TOPK_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        top_k <= cfg_data;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (commit) begin
            fill_count <= fill_next;
            if (item.operation == btq_pkg::OP_OFFER) begin
              iteration <= iter_inc;
            end
            state <= accept ? S_EVAL : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= btq_pkg::COUNT_W'(btq_pkg::MAX_SLOTS))
    else $error("entry count beyond slot count");

  a_keys_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> $onehot0(match_mask))
    else $error("key held in more than one slot");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("result beat raised outside decide step");

  a_fill_steady_on_read: assert property (@(posedge clk) disable iff (rst)
    (commit && (item.operation == btq_pkg::OP_READ)) |=> $stable(fill_count))
    else $error("read changed entry count");

endmodule

### hdl/btq_cell.sv
// ----------------------------------------------------------------------------
// btq_cell
// One queue slot: holds an entry, compares it with the offered pattern, adds
// graphs to it and moves data to or from its neighbors on an insert.
// ----------------------------------------------------------------------------
module btq_cell (
  input  logic                      clk,
  input  logic [btq_pkg::SLOT_W-1:0] cell_index,
  input  btq_pkg::probe_t           probe,
  input  btq_pkg::cmd_t             cmd,
  input  btq_pkg::entry_t           below,
  input  btq_pkg::entry_t           above,
  output btq_pkg::entry_t           entry,
  output btq_pkg::flags_t           flags
);

  btq_pkg::entry_t entry_next;
  btq_pkg::flags_t flags_next;
  btq_pkg::entry_t fresh;

  always_comb begin
    fresh         = '0;
    fresh.key     = probe.key;
    fresh.score   = probe.score;
    fresh.graphs  = btq_pkg::NUM_GRAPHS'(1) << probe.graph_index;
    fresh.stamp   = probe.stamp;
    fresh.support = btq_pkg::SUPPORT_W'(1);
  end

  always_comb begin
    entry_next = entry;
    case (cmd.action)
      btq_pkg::ACT_ADD_GRAPH: begin
        if (cmd.target == cell_index) begin
          entry_next.graphs[probe.graph_index] = 1'b1;
          entry_next.support = entry.support + btq_pkg::SUPPORT_W'(1);
          entry_next.stamp   = probe.stamp;
        end
      end
      btq_pkg::ACT_INSERT: begin
        if (cmd.target == cell_index) begin
          entry_next = fresh;
        end else if (cmd.evict && (cell_index < cmd.target)) begin
          entry_next = above;
        end else if (!cmd.evict && (cell_index > cmd.target)) begin
          entry_next = below;
        end
      end
      default: begin
      end
    endcase
  end

  // new entry has support 1; ties fall to score, then time stamp
  always_comb begin
    flags_next.match     = (entry.key == probe.key);
    flags_next.has_graph = entry.graphs[probe.graph_index];
    if (entry.support != btq_pkg::SUPPORT_W'(1)) begin
      flags_next.ranks_below = (entry.support > btq_pkg::SUPPORT_W'(1));
    end else if (entry.score != probe.score) begin
      flags_next.ranks_below = (probe.score < entry.score);
    end else begin
      flags_next.ranks_below = (probe.stamp < entry.stamp);
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    flags <= flags_next;
  end

endmodule

### verif/bounded_topk_sorted_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_topk_sorted_queue_unit_test
// Self-checking bench for the bounded top-k sorted queue. Offers and reads are
// driven with random gaps and output stalls. A behavioral copy of the queue
// predicts each result beat, and every beat is checked field by field. The
// capacity register is swept across all of its values, including a drop in
// capacity while the queue is full.
// ----------------------------------------------------------------------------
module bounded_topk_sorted_queue_unit_test;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  btq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  btq_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [btq_pkg::TOPK_W-1:0] cfg_data;

  bounded_topk_sorted_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // behavioral copy of the queue
  logic [btq_pkg::KEY_W-1:0]          held_key    [btq_pkg::MAX_SLOTS];
  logic signed [btq_pkg::SCORE_W-1:0] held_score  [btq_pkg::MAX_SLOTS];
  logic [btq_pkg::NUM_GRAPHS-1:0]     held_graphs [btq_pkg::MAX_SLOTS];
  logic [btq_pkg::STAMP_W-1:0]        held_stamp  [btq_pkg::MAX_SLOTS];
  int                                 held_count;
  logic [btq_pkg::STAMP_W-1:0]        offer_clock;
  logic [btq_pkg::TOPK_W-1:0]         topk_setting;

  btq_pkg::out_item_t pending_results[$];
  logic [31:0]        key_pool[12];
  int                 mismatches;
  int                 beats_sent;
  int                 results_seen;
  int                 status_seen[8];
  int                 cycles;
  bit                 calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_results.size());
    $display("bounded_topk_sorted_queue_unit_test: done, errors");
    $finish;
  end

  // output stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    btq_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending, status", out_data.status, 0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        status_seen[want.status]++;
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.slot !== want.slot)
          report_mismatch("slot", out_data.slot, want.slot);
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_data.entry_count, want.entry_count);
        if (out_data.entry_key !== want.entry_key)
          report_mismatch("entry_key", out_data.entry_key, want.entry_key);
        if (out_data.entry_support !== want.entry_support)
          report_mismatch("entry_support", out_data.entry_support, want.entry_support);
        if (out_data.entry_score !== want.entry_score)
          report_mismatch("entry_score", out_data.entry_score, want.entry_score);
        if (out_data.entry_time !== want.entry_time)
          report_mismatch("entry_time", out_data.entry_time, want.entry_time);
      end
    end
  end

  function automatic btq_pkg::out_item_t entry_view(btq_pkg::status_t st, int s, bit show);
    btq_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.slot = btq_pkg::SLOT_W'(s);
    r.entry_count = btq_pkg::COUNT_W'(held_count);
    if (show && s < held_count) begin
      r.entry_key = held_key[s];
      r.entry_support = btq_pkg::SUPPORT_W'($countones(held_graphs[s]));
      r.entry_score = held_score[s];
      r.entry_time = held_stamp[s];
    end
    return r;
  endfunction

  // true when entry a sorts strictly below entry b
  function automatic bit ranks_lower(logic [btq_pkg::NUM_GRAPHS-1:0] ga,
                                     logic signed [btq_pkg::SCORE_W-1:0] sa,
                                     logic [btq_pkg::STAMP_W-1:0] ta,
                                     logic [btq_pkg::NUM_GRAPHS-1:0] gb,
                                     logic signed [btq_pkg::SCORE_W-1:0] sb,
                                     logic [btq_pkg::STAMP_W-1:0] tb);
    int pa, pb;
    pa = $countones(ga);
    pb = $countones(gb);
    if (pa != pb) return pa < pb;
    if (sa != sb) return sa < sb;
    return ta < tb;
  endfunction

  function automatic btq_pkg::out_item_t next_queue_result(btq_pkg::in_item_t it);
    int cap, half, pos, k;
    longint sum;
    logic signed [btq_pkg::SCORE_W-1:0] sc;
    logic [btq_pkg::NUM_GRAPHS-1:0] gbit;
    bit full;
    btq_pkg::status_t st;
    if (it.operation == btq_pkg::OP_READ)
      return entry_view(btq_pkg::ST_READ, it.read_index, 1'b1);
    offer_clock = offer_clock + 1;
    sc = it.sample_score;
    k = (topk_setting == 0) ? 1 : topk_setting;
    cap = (2 * k > btq_pkg::MAX_SLOTS) ? btq_pkg::MAX_SLOTS : 2 * k;
    full = held_count >= cap;
    if (it.graph_index >= btq_pkg::NUM_GRAPHS)
      return entry_view(btq_pkg::ST_REJECTED, 0, 1'b0);
    if (full) begin
      half = held_count / 2;
      sum = 0;
      for (int i = 0; i < half; i++) sum += longint'(held_score[i]);
      if (longint'(sc) * longint'(half) < sum)
        return entry_view(btq_pkg::ST_REJECTED, 0, 1'b0);
    end
    gbit = btq_pkg::NUM_GRAPHS'(1) << it.graph_index;
    for (int i = 0; i < held_count; i++) begin
      if (held_key[i] == it.pattern_key) begin
        if ((held_graphs[i] & gbit) == '0) begin
          held_graphs[i] |= gbit;
          held_stamp[i] = offer_clock;
          return entry_view(btq_pkg::ST_ADDED, i, 1'b1);
        end
        return entry_view(btq_pkg::ST_PRESENT, i, 1'b1);
      end
    end
    st = btq_pkg::ST_INSERTED;
    if (full && held_count > 0) begin
      for (int i = 1; i < held_count; i++) begin
        held_key[i-1] = held_key[i];
        held_score[i-1] = held_score[i];
        held_graphs[i-1] = held_graphs[i];
        held_stamp[i-1] = held_stamp[i];
      end
      held_count--;
      st = btq_pkg::ST_EVICTED;
    end
    if (held_count >= btq_pkg::MAX_SLOTS) return entry_view(btq_pkg::ST_REJECTED, 0, 1'b0);
    pos = held_count;
    while (pos > 0 && ranks_lower(gbit, sc, offer_clock, held_graphs[pos-1],
                                  held_score[pos-1], held_stamp[pos-1])) begin
      held_key[pos] = held_key[pos-1];
      held_score[pos] = held_score[pos-1];
      held_graphs[pos] = held_graphs[pos-1];
      held_stamp[pos] = held_stamp[pos-1];
      pos--;
    end
    held_key[pos] = it.pattern_key;
    held_score[pos] = sc;
    held_graphs[pos] = gbit;
    held_stamp[pos] = offer_clock;
    held_count++;
    return entry_view(st, pos, 1'b1);
  endfunction

  function automatic btq_pkg::in_item_t offer(logic [btq_pkg::KEY_W-1:0] key, int gid,
                                              logic [btq_pkg::SCORE_W-1:0] sc);
    btq_pkg::in_item_t it;
    it = '0;
    it.operation = btq_pkg::OP_OFFER;
    it.pattern_key = key;
    it.graph_index = btq_pkg::GID_W'(gid);
    it.sample_score = sc;
    it.read_index = btq_pkg::SLOT_W'($urandom);
    return it;
  endfunction

  function automatic btq_pkg::in_item_t read_at(int idx);
    btq_pkg::in_item_t it;
    it = '0;
    it.operation = btq_pkg::OP_READ;
    it.pattern_key = $urandom;
    it.graph_index = btq_pkg::GID_W'($urandom);
    it.sample_score = $urandom;
    it.read_index = btq_pkg::SLOT_W'(idx);
    return it;
  endfunction

  task automatic send_beat(btq_pkg::in_item_t it);
    btq_pkg::out_item_t r;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    r = next_queue_result(it);
    pending_results.insert(pending_results.size(), r);
    beats_sent++;
  endtask

  task automatic drain_inputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_topk(logic [btq_pkg::TOPK_W-1:0] v);
    drain_inputs();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    topk_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_reads();
    send_beat(read_at(0));
    send_beat(read_at(7));
  endtask

  // default capacity of six: fill, repeat key, full-queue reject and evict
  task automatic test_fill_reject_evict();
    send_beat(offer(32'h0000_0000, 0, 32'h8000_0000));
    send_beat(offer(32'hFFFF_FFFF, 63, 32'h7FFF_FFFF));
    send_beat(offer(32'h0000_1234, 5, 32'h0001_0000));
    send_beat(offer(32'h0000_1234, 6, 32'h0004_0000));
    send_beat(offer(32'h0000_1234, 6, 32'h0004_0000));
    send_beat(offer(32'h00AB_0001, 1, 32'h0002_0000));
    send_beat(offer(32'h00AB_0002, 2, 32'h0002_0000));
    send_beat(offer(32'h00AB_0003, 3, 32'hFFFF_0000));
    send_beat(offer(32'h00AB_0004, 3, 32'h8000_0000));
    send_beat(offer(32'h00AB_0005, 4, 32'h7FFF_FFFF));
    for (int i = 0; i < btq_pkg::MAX_SLOTS; i++) send_beat(read_at(i));
  endtask

  // capacity floor while the queue is full, then the saturated ceiling
  task automatic test_capacity_extremes();
    write_topk(3'd0);
    send_beat(offer(32'h00CD_0001, 9, 32'h7FFF_0000));
    send_beat(read_at(0));
    write_topk(3'd7);
    send_beat(offer(32'h00CD_0002, 10, 32'h0000_8000));
    send_beat(offer(32'h00CD_0003, 11, 32'h0000_8000));
  endtask

  function automatic btq_pkg::in_item_t random_beat();
    logic [btq_pkg::KEY_W-1:0] key;
    logic [btq_pkg::SCORE_W-1:0] sc;
    int gid;
    if ($urandom_range(0, 4) == 0) return read_at($urandom_range(0, 7));
    key = ($urandom_range(0, 19) < 17) ? key_pool[$urandom_range(0, 11)] : $urandom;
    gid = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: sc = 32'h8000_0000;
      1: sc = 32'h7FFF_FFFF;
      2, 3, 4: sc = $urandom;
      default: sc = ($urandom_range(0, 16) - 8) * 65536;
    endcase
    return offer(key, gid, sc);
  endfunction

  task automatic test_random_traffic();
    logic [btq_pkg::TOPK_W-1:0] sweep[8];
    sweep = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd5, 3'd3, 3'd6};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = $urandom;
    for (int p = 0; p < 8; p++) begin
      write_topk(sweep[p]);
      if (p == 7) calm = 1'b1;
      for (int n = 0; n < 105; n++) send_beat(random_beat());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    results_seen = 0;
    held_count = 0;
    offer_clock = '0;
    topk_setting = btq_pkg::TOPK_RESET;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_reads();
    test_fill_reject_evict();
    test_capacity_extremes();
    test_random_traffic();

    drain_inputs();
    repeat (8) @(posedge clk);
    $display("%0d beats in, %0d results checked over top_k 0..7", beats_sent, results_seen);
    $display("rejected %0d, added %0d, present %0d, inserted %0d, evicted %0d, read %0d",
             status_seen[btq_pkg::ST_REJECTED], status_seen[btq_pkg::ST_ADDED],
             status_seen[btq_pkg::ST_PRESENT], status_seen[btq_pkg::ST_INSERTED],
             status_seen[btq_pkg::ST_EVICTED], status_seen[btq_pkg::ST_READ]);
    if (mismatches == 0) begin
      $display("bounded_topk_sorted_queue_unit_test: done, clean");
    end else begin
      $display("bounded_topk_sorted_queue_unit_test: done, errors");
    end
    $finish;
  end

endmodule

### bounded_topk_sorted_queue_unit.f
hdl/btq_pkg.sv
hdl/btq_cell.sv
hdl/bounded_topk_sorted_queue_unit.sv
verif/bounded_topk_sorted_queue_unit_test.sv
